[hdl/pcmx_pkg.sv]
// shared types, request codes and arithmetic constants of the pcm channel mixer
`timescale 1ns / 1ps

package pcmx_pkg;

    localparam int VOICES_DEF    = 8;
    localparam int MEM_DEPTH_DEF = 32768;

    // request codes on req_type
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_SETP  = 3'd3;
    localparam logic [2:0] REQ_QUERY = 3'd4;
    localparam logic [2:0] REQ_TICK  = 3'd5;

    localparam int MIX_HZ     = 11025;
    localparam int PAN_FULL   = 254;
    localparam int WEIGHT_DIV = 254 * 127;

    // step = (rate << 16) / MIX_HZ taken as rate * DIV_MULT >> DIV_SHIFT,
    // exact for every 16-bit rate; quotient below 2^19
    localparam int     DIV_SHIFT = 30;
    localparam longint DIV_MULT  = ((longint'(1) <<< (DIV_SHIFT + 16)) + MIX_HZ - 1) / MIX_HZ;
    localparam int     DIV_PW    = 49;
    localparam int     STEP_W    = 19;

    // exact reciprocal of the weight divisor for products below 2^30
    localparam int      REC_SHIFT = 45;
    localparam longint  REC_MULT  = ((longint'(1) <<< REC_SHIFT) + WEIGHT_DIV - 1) / WEIGHT_DIV;
    localparam int      PROD_W    = 16;
    localparam int      XW        = 23;
    localparam int      PW        = 54;
    // the sample is scaled by 256 before the divide, folded into the shift
    localparam int      QSHIFT    = REC_SHIFT - 8;

    typedef enum logic [2:0] {
        K_WRITE,
        K_START,
        K_STOP,
        K_SETP,
        K_QUERY,
        K_TICK,
        K_NONE
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SET,
        ST_FETCH,
        ST_MUL1,
        ST_MUL2,
        ST_REC,
        ST_ACC,
        ST_FIN
    } bstate_t;

    typedef struct packed {
        kind_t       kind;
        logic        wr_ok;
        logic        start_ok;
        logic [14:0] mem_address;
        logic [7:0]  sample_byte;
        logic [15:0] rate_hz;
        logic [15:0] sample_total;
        logic [3:0]  voice_handle;
        logic [6:0]  gain;
        logic [7:0]  pan;
    } item_t;

    typedef struct packed {
        logic [3:0]         handle_out;
        logic               is_playing;
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               audible;
    } result_t;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
            r = 16'sh7fff;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[hdl/pcmx_ifs.sv]
// request and response channel interfaces of the pcm channel mixer
`timescale 1ns / 1ps

interface pcmx_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [14:0] mem_address;
    logic [7:0]  sample_byte;
    logic [15:0] rate_hz;
    logic [15:0] sample_total;
    logic [3:0]  voice_handle;
    logic [6:0]  gain;
    logic [7:0]  pan;

    modport source (output valid, req_type, mem_address, sample_byte, rate_hz,
                    sample_total, voice_handle, gain, pan, input ready);
    modport sink   (input valid, req_type, mem_address, sample_byte, rate_hz,
                    sample_total, voice_handle, gain, pan, output ready);
endinterface

interface pcmx_rsp_if;
    logic               valid;
    logic               ready;
    logic [3:0]         handle_out;
    logic               is_playing;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               audible;

    modport source (output valid, handle_out, is_playing, left_out, right_out, audible,
                    input ready);
    modport sink   (input valid, handle_out, is_playing, left_out, right_out, audible,
                    output ready);
endinterface

[hdl/pcmx_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pcmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pcmx_front.sv]
// request intake: classifies each beat and holds it in a two-entry queue
`timescale 1ns / 1ps

module pcmx_front #(
    parameter int SAMPLE_MEM_DEPTH = pcmx_pkg::MEM_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    pcmx_cmd_if.sink        cmd,
    output pcmx_pkg::item_t head,
    output logic            head_valid,
    input  logic            head_pop
);

    pcmx_pkg::item_t q_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    pcmx_pkg::item_t item_in;
    logic            push;
    logic            pop;

    always_comb
    begin
        item_in.mem_address  = cmd.mem_address;
        item_in.sample_byte  = cmd.sample_byte;
        item_in.rate_hz      = cmd.rate_hz;
        item_in.sample_total = cmd.sample_total;
        item_in.voice_handle = cmd.voice_handle;
        item_in.gain         = cmd.gain;
        item_in.pan          = (cmd.pan == 8'hff) ? 8'(pcmx_pkg::PAN_FULL) : cmd.pan;
        item_in.wr_ok        = 32'(cmd.mem_address) < 32'(SAMPLE_MEM_DEPTH);
        item_in.start_ok     = (cmd.rate_hz != 16'd0) && (cmd.sample_total != 16'd0) &&
                               (32'(cmd.mem_address) + 32'(cmd.sample_total)
                                <= 32'(SAMPLE_MEM_DEPTH));
        case (cmd.req_type)
            pcmx_pkg::REQ_WRITE: item_in.kind = pcmx_pkg::K_WRITE;
            pcmx_pkg::REQ_START: item_in.kind = pcmx_pkg::K_START;
            pcmx_pkg::REQ_STOP:  item_in.kind = pcmx_pkg::K_STOP;
            pcmx_pkg::REQ_SETP:  item_in.kind = pcmx_pkg::K_SETP;
            pcmx_pkg::REQ_QUERY: item_in.kind = pcmx_pkg::K_QUERY;
            pcmx_pkg::REQ_TICK:  item_in.kind = pcmx_pkg::K_TICK;
            default:             item_in.kind = pcmx_pkg::K_NONE;
        endcase
    end

    assign cmd.ready  = (cnt_reg != 2'd2);
    assign push       = cmd.valid && cmd.ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head       = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= item_in;
    end

endmodule

[hdl/pcmx_back.sv]
// request execution: voice table, step reciprocal, mixing datapath and result register
`timescale 1ns / 1ps

module pcmx_back #(
    parameter int VOICES           = pcmx_pkg::VOICES_DEF,
    parameter int SAMPLE_MEM_DEPTH = pcmx_pkg::MEM_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pcmx_pkg::item_t head,
    input  logic            head_valid,
    output logic            head_pop,
    pcmx_rsp_if.source      rsp
);

    localparam int SW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW    = $clog2(SAMPLE_MEM_DEPTH);
    localparam int ACC_W = $clog2(VOICES + 1) + 17;

    pcmx_pkg::bstate_t state_reg, state_next;
    logic [SW-1:0]     vidx_reg, vidx_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [VOICES-1:0] active_reg, active_next;
    pcmx_pkg::result_t res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic [pcmx_pkg::STEP_W-1:0] quo_reg, quo_next;
    logic signed [ACC_W-1:0]     acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0]     acc_r_reg, acc_r_next;
    logic                        aud_reg, aud_next;
    logic                        neg_reg, neg_next;
    logic [pcmx_pkg::PROD_W-1:0] prod_l_reg, prod_l_next;
    logic [pcmx_pkg::PROD_W-1:0] prod_r_reg, prod_r_next;
    logic [pcmx_pkg::XW-1:0]     x_l_reg, x_l_next;
    logic [pcmx_pkg::XW-1:0]     x_r_reg, x_r_next;
    logic [pcmx_pkg::PW-1:0]     p_l_reg, p_l_next;
    logic [pcmx_pkg::PW-1:0]     p_r_reg, p_r_next;

    // voice table
    logic [14:0]                 base_reg [VOICES];
    logic [15:0]                 len_reg  [VOICES];
    logic [31:0]                 pos_reg  [VOICES];
    logic [pcmx_pkg::STEP_W-1:0] step_reg [VOICES];
    logic [6:0]                  gain_reg [VOICES];
    logic [7:0]                  pan_reg  [VOICES];

    logic                        vw_start, vw_setp, vw_pos;
    logic                        ram_we;
    logic [AW-1:0]               rd_addr;
    logic [7:0]                  ram_rdata;

    logic                        slot_ok;
    logic [3:0]                  hm1;
    logic [SW-1:0]               slot_h;
    logic                        free_ok;
    logic [SW-1:0]               free_idx;
    logic [14:0]                 base_cur;
    logic [15:0]                 len_cur;
    logic [31:0]                 pos_cur;
    logic [6:0]                  gain_cur;
    logic [7:0]                  pan_cur;
    logic [15:0]                 idx_cur;
    logic [pcmx_pkg::DIV_PW-1:0] step_prod;
    logic [pcmx_pkg::STEP_W-1:0] step_val;
    logic                        neg_s;
    logic [7:0]                  mag;
    logic [7:0]                  wl;
    logic [15:0]                 ql, qr;
    logic signed [ACC_W-1:0]     cl, cr;
    logic                        res_free;
    logic                        last_voice;
    pcmx_pkg::result_t           zero_res;

    pcmx_ram #(
        .WIDTH (8),
        .DEPTH (SAMPLE_MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(head.mem_address)),
        .wdata (head.sample_byte),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rsp.valid      = res_valid_reg;
    assign rsp.handle_out = res_reg.handle_out;
    assign rsp.is_playing = res_reg.is_playing;
    assign rsp.left_out   = res_reg.left_out;
    assign rsp.right_out  = res_reg.right_out;
    assign rsp.audible    = res_reg.audible;

    always_comb
    begin
        slot_ok  = (head.voice_handle != 4'd0) && (32'(head.voice_handle) <= VOICES);
        hm1      = head.voice_handle - 4'd1;
        slot_h   = SW'(hm1);
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SW'(i);
            end
        end

        base_cur = base_reg[vidx_reg];
        len_cur  = len_reg[vidx_reg];
        pos_cur  = pos_reg[vidx_reg];
        gain_cur = gain_reg[vidx_reg];
        pan_cur  = pan_reg[vidx_reg];
        idx_cur  = pos_cur[31:16];
        rd_addr  = AW'(32'(base_cur) + 32'(idx_cur));

        // rate << 16 over the mix rate by reciprocal multiplication
        step_prod = pcmx_pkg::DIV_PW'(head.rate_hz) * pcmx_pkg::DIV_PW'(pcmx_pkg::DIV_MULT);
        step_val  = (quo_reg == '0) ? pcmx_pkg::STEP_W'(1) : quo_reg;

        neg_s    = ram_rdata < 8'd128;
        mag      = neg_s ? (8'd128 - ram_rdata) : (ram_rdata - 8'd128);
        wl       = 8'(pcmx_pkg::PAN_FULL) - pan_cur;

        ql = p_l_reg[pcmx_pkg::QSHIFT+15:pcmx_pkg::QSHIFT];
        qr = p_r_reg[pcmx_pkg::QSHIFT+15:pcmx_pkg::QSHIFT];
        cl = $signed(ACC_W'(ql));
        cr = $signed(ACC_W'(qr));
        if (neg_reg)
        begin
            cl = -cl;
            cr = -cr;
        end

        res_free   = !res_valid_reg || rsp.ready;
        last_voice = (vidx_reg == SW'(VOICES - 1));
        zero_res   = '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        vidx_next      = vidx_reg;
        slot_next      = slot_reg;
        active_next    = active_reg;
        res_next       = res_reg;
        res_valid_next = (res_valid_reg && !rsp.ready);
        quo_next       = quo_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        aud_next       = aud_reg;
        neg_next       = neg_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        x_l_next       = x_l_reg;
        x_r_next       = x_r_reg;
        p_l_next       = p_l_reg;
        p_r_next       = p_r_reg;
        vw_start       = 1'b0;
        vw_setp        = 1'b0;
        vw_pos         = 1'b0;
        ram_we         = 1'b0;
        head_pop       = 1'b0;

        case (state_reg)
            pcmx_pkg::ST_IDLE:
            begin
                if (head_valid && res_free)
                begin
                    case (head.kind)
                        pcmx_pkg::K_START:
                        begin
                            if (head.start_ok && free_ok)
                            begin
                                slot_next  = free_idx;
                                quo_next   = '0;
                                state_next = pcmx_pkg::ST_DIV;
                            end
                            else
                            begin
                                res_next       = zero_res;
                                res_valid_next = 1'b1;
                                head_pop       = 1'b1;
                            end
                        end
                        pcmx_pkg::K_TICK:
                        begin
                            vidx_next  = '0;
                            acc_l_next = '0;
                            acc_r_next = '0;
                            aud_next   = 1'b0;
                            state_next = pcmx_pkg::ST_FETCH;
                        end
                        default:
                        begin
                            res_next       = zero_res;
                            res_valid_next = 1'b1;
                            head_pop       = 1'b1;
                            if (head.kind == pcmx_pkg::K_WRITE)
                                ram_we = head.wr_ok;
                            if (head.kind == pcmx_pkg::K_STOP && slot_ok)
                                active_next[slot_h] = 1'b0;
                            if (head.kind == pcmx_pkg::K_SETP && slot_ok)
                                vw_setp = active_reg[slot_h];
                            if (head.kind == pcmx_pkg::K_QUERY && slot_ok)
                                res_next.is_playing = active_reg[slot_h];
                        end
                    endcase
                end
            end
            pcmx_pkg::ST_DIV:
            begin
                quo_next   = step_prod[pcmx_pkg::DIV_PW-1:pcmx_pkg::DIV_SHIFT];
                state_next = pcmx_pkg::ST_SET;
            end
            pcmx_pkg::ST_SET:
            begin
                vw_start              = 1'b1;
                active_next[slot_reg] = 1'b1;
                res_next              = zero_res;
                res_next.handle_out   = 4'(32'(slot_reg) + 32'd1);
                res_valid_next        = 1'b1;
                head_pop              = 1'b1;
                state_next            = pcmx_pkg::ST_IDLE;
            end
            pcmx_pkg::ST_FETCH:
            begin
                if (active_reg[vidx_reg] && idx_cur < len_cur)
                    state_next = pcmx_pkg::ST_MUL1;
                else
                begin
                    active_next[vidx_reg] = 1'b0;
                    if (last_voice)
                        state_next = pcmx_pkg::ST_FIN;
                    else
                        vidx_next = vidx_reg + SW'(1);
                end
            end
            pcmx_pkg::ST_MUL1:
            begin
                prod_l_next = {8'd0, mag} * {8'd0, wl};
                prod_r_next = {8'd0, mag} * {8'd0, pan_cur};
                neg_next    = neg_s;
                aud_next    = 1'b1;
                vw_pos      = 1'b1;
                state_next  = pcmx_pkg::ST_MUL2;
            end
            pcmx_pkg::ST_MUL2:
            begin
                x_l_next   = pcmx_pkg::XW'(prod_l_reg) * pcmx_pkg::XW'(gain_cur);
                x_r_next   = pcmx_pkg::XW'(prod_r_reg) * pcmx_pkg::XW'(gain_cur);
                state_next = pcmx_pkg::ST_REC;
            end
            pcmx_pkg::ST_REC:
            begin
                p_l_next   = pcmx_pkg::PW'(x_l_reg) * pcmx_pkg::PW'(pcmx_pkg::REC_MULT);
                p_r_next   = pcmx_pkg::PW'(x_r_reg) * pcmx_pkg::PW'(pcmx_pkg::REC_MULT);
                state_next = pcmx_pkg::ST_ACC;
            end
            pcmx_pkg::ST_ACC:
            begin
                acc_l_next = acc_l_reg + cl;
                acc_r_next = acc_r_reg + cr;
                if (last_voice)
                    state_next = pcmx_pkg::ST_FIN;
                else
                begin
                    vidx_next  = vidx_reg + SW'(1);
                    state_next = pcmx_pkg::ST_FETCH;
                end
            end
            pcmx_pkg::ST_FIN:
            begin
                res_next           = zero_res;
                res_next.left_out  = pcmx_pkg::sat16(32'(acc_l_reg));
                res_next.right_out = pcmx_pkg::sat16(32'(acc_r_reg));
                res_next.audible   = aud_reg;
                res_valid_next     = 1'b1;
                head_pop           = 1'b1;
                state_next         = pcmx_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcmx_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcmx_pkg::ST_IDLE;
            vidx_reg      <= '0;
            slot_reg      <= '0;
            active_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vidx_reg      <= vidx_next;
            slot_reg      <= slot_next;
            active_reg    <= active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        quo_reg    <= quo_next;
        acc_l_reg  <= acc_l_next;
        acc_r_reg  <= acc_r_next;
        aud_reg    <= aud_next;
        neg_reg    <= neg_next;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        x_l_reg    <= x_l_next;
        x_r_reg    <= x_r_next;
        p_l_reg    <= p_l_next;
        p_r_reg    <= p_r_next;
        if (vw_start)
        begin
            base_reg[slot_reg] <= head.mem_address;
            len_reg[slot_reg]  <= head.sample_total;
            pos_reg[slot_reg]  <= 32'd0;
            step_reg[slot_reg] <= step_val;
            gain_reg[slot_reg] <= head.gain;
            pan_reg[slot_reg]  <= head.pan;
        end
        if (vw_setp)
        begin
            gain_reg[slot_h] <= head.gain;
            pan_reg[slot_h]  <= head.pan;
        end
        if (vw_pos)
            pos_reg[vidx_reg] <= pos_cur + 32'(step_reg[vidx_reg]);
    end

endmodule

[hdl/pcm_channel_mixer.sv]
// top level of the pcm channel mixer with stereo pan, eight voices by default
`timescale 1ns / 1ps

// channel  role      beat carries
// cmd      sink      req_type, mem_address, sample_byte, rate_hz, sample_total,
//                    voice_handle, gain, pan
// rsp      source    handle_out, is_playing, left_out, right_out, audible
//
// write, stop, set params, query and rejected start: handled in the idle state of the back end
// accepted start: idle, divide and set states; the step comes from one reciprocal multiply
// tick: fetch for every voice, mul1, mul2, rec and acc for each playing voice, then fin; one sample ram read per voice
// reset clears voice activity and both handshakes; sample ram is not cleared
// a two-beat queue lets cmd take beats while a result waits on a stalled rsp, until the queue is full

module pcm_channel_mixer #(
    parameter int VOICES           = pcmx_pkg::VOICES_DEF,
    parameter int SAMPLE_MEM_DEPTH = pcmx_pkg::MEM_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pcmx_cmd_if.sink   cmd,
    pcmx_rsp_if.source rsp
);

    // classified request at the head of the queue
    pcmx_pkg::item_t head;
    logic            head_valid;
    logic            head_pop;

    // front end: takes beats, decodes the request kind, checks ranges
    pcmx_front #(
        .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // back end: voice table, sample ram, mixing and the result register
    pcmx_back #(
        .VOICES           (VOICES),
        .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .rsp        (rsp)
    );

endmodule

[hdl/pcmx_checker.sv]
// port-level checks on the pcm channel mixer response channel, bound to the top level
`timescale 1ns / 1ps

module pcmx_checker #(
    parameter int VOICES = pcmx_pkg::VOICES_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [3:0]         handle_out,
    input logic               is_playing,
    input logic signed [15:0] left_out,
    input logic signed [15:0] right_out,
    input logic               audible
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_handle_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && handle_out != 4'd0 |->
            !is_playing && !audible && left_out == 16'sd0 && right_out == 16'sd0)
        else $error("start result carries other fields");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !audible |-> left_out == 16'sd0 && right_out == 16'sd0)
        else $error("mix output without a contributing voice");

    a_handle_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(handle_out) <= VOICES)
        else $error("handle beyond voice count");

endmodule

bind pcm_channel_mixer pcmx_checker #(
    .VOICES (VOICES)
) u_pcmx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .handle_out (rsp.handle_out),
    .is_playing (rsp.is_playing),
    .left_out   (rsp.left_out),
    .right_out  (rsp.right_out),
    .audible    (rsp.audible)
);

[sim/pcm_channel_mixer_checker.sv]
// checker for the pcm channel mixer: watches both channels, predicts every result and compares
`timescale 1ns / 1ps

module pcm_channel_mixer_checker
    import pcmx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pcmx_cmd_if.sink   cmd,
    pcmx_rsp_if.sink   rsp,
    output int         fail_count,
    output int         pending_count
);

    localparam int NV    = VOICES_DEF;
    localparam int DEPTH = MEM_DEPTH_DEF;

    logic [7:0]  mix_mem [DEPTH];
    logic        v_on    [NV];
    logic [14:0] v_base  [NV];
    logic [15:0] v_len   [NV];
    logic [31:0] v_pos   [NV];
    logic [31:0] v_step  [NV];
    int          v_gain  [NV];
    int          v_pan   [NV];

    result_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic int clip_pan(input logic [7:0] p);
        return (p > PAN_FULL) ? PAN_FULL : int'(p);
    endfunction

    function automatic logic signed [15:0] clamp_mix(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // advance the voice bank by one request beat and return its response
    function automatic result_t mix_request(
        input logic [2:0] req, input logic [14:0] addr, input logic [7:0] data,
        input logic [15:0] rate, input logic [15:0] total, input logic [3:0] hnd,
        input logic [6:0] g, input logic [7:0] p);
        result_t r;
        int      slot;
        int      i;
        int      lsum;
        int      rsum;
        int      s;
        logic [31:0] idx;
        logic [31:0] st;
        r = '0;
        slot = (hnd >= 1 && hnd <= NV) ? int'(hnd) - 1 : -1;
        lsum = 0;
        rsum = 0;
        case (req)
            REQ_WRITE: mix_mem[addr] = data;
            REQ_START:
            begin
                if (rate != 0 && total != 0 && int'(addr) + int'(total) <= DEPTH)
                begin
                    for (i = 0; i < NV; i++)
                        if (!v_on[i])
                            break;
                    if (i < NV)
                    begin
                        st = ({16'd0, rate} << 16) / MIX_HZ;
                        v_base[i] = addr;
                        v_len[i]  = total;
                        v_pos[i]  = 0;
                        v_step[i] = (st == 0) ? 32'd1 : st;
                        v_gain[i] = int'(g);
                        v_pan[i]  = clip_pan(p);
                        v_on[i]   = 1'b1;
                        r.handle_out = 4'(i + 1);
                    end
                end
            end
            REQ_STOP: if (slot >= 0) v_on[slot] = 1'b0;
            REQ_SETP:
            begin
                if (slot >= 0 && v_on[slot])
                begin
                    v_gain[slot] = int'(g);
                    v_pan[slot]  = clip_pan(p);
                end
            end
            REQ_QUERY: r.is_playing = (slot >= 0) && v_on[slot];
            REQ_TICK:
            begin
                for (i = 0; i < NV; i++)
                begin
                    if (!v_on[i])
                        continue;
                    idx = v_pos[i] >> 16;
                    if (idx >= v_len[i])
                    begin
                        v_on[i] = 1'b0;
                        continue;
                    end
                    s = (int'(mix_mem[v_base[i] + idx]) - 128) * 256;
                    lsum += s * (PAN_FULL - v_pan[i]) * v_gain[i] / WEIGHT_DIV;
                    rsum += s * v_pan[i] * v_gain[i] / WEIGHT_DIV;
                    v_pos[i] += v_step[i];
                    r.audible = 1'b1;
                end
                r.left_out  = clamp_mix(lsum);
                r.right_out = clamp_mix(rsum);
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            for (int i = 0; i < NV; i++)
                v_on[i] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.handle_out, rsp.is_playing, rsp.left_out, rsp.right_out,
                        rsp.audible};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                expected_results.push_back(mix_request(cmd.req_type, cmd.mem_address,
                    cmd.sample_byte, cmd.rate_hz, cmd.sample_total, cmd.voice_handle,
                    cmd.gain, cmd.pan));
        end
    end

endmodule

[sim/pcm_channel_mixer_tb.sv]
// testbench top of the pcm channel mixer: request stimulus, response stalls and verdict
`timescale 1ns / 1ps

module pcm_channel_mixer_tb;
    import pcmx_pkg::*;

    localparam int SOUND_BYTES = 256;   // region of sample memory that stimulus fills

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    bit   long_hold;

    pcmx_cmd_if cmd ();
    pcmx_rsp_if rsp ();

    pcm_channel_mixer dut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));

    pcm_channel_mixer_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count));

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // send one request beat, holding valid until it is taken
    task automatic send_req(input logic [2:0] req, input logic [14:0] addr,
                            input logic [7:0] data, input logic [15:0] rate,
                            input logic [15:0] total, input logic [3:0] hnd,
                            input logic [6:0] g, input logic [7:0] p);
        cmd.valid        <= 1'b1;
        cmd.req_type     <= req;
        cmd.mem_address  <= addr;
        cmd.sample_byte  <= data;
        cmd.rate_hz      <= rate;
        cmd.sample_total <= total;
        cmd.voice_handle <= hnd;
        cmd.gain         <= g;
        cmd.pan          <= p;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic drop_valid();
        cmd.valid <= 1'b0;
    endtask

    // start with random content; sounds stay inside the written region
    task automatic send_start(input bit full_range);
        int base;
        int cnt;
        base = $urandom_range(0, SOUND_BYTES - 1);
        cnt  = $urandom_range(1, full_range ? 40 : SOUND_BYTES - base);
        if (cnt > SOUND_BYTES - base)
            cnt = SOUND_BYTES - base;
        send_req(REQ_START, 15'(base), 8'($urandom), 16'($urandom_range(1, 65535)),
                 16'(cnt), 4'($urandom), 7'($urandom), 8'($urandom));
    endtask

    // response side: random stall pattern plus one long hold-off
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 3))
                0: rsp.ready <= ($urandom_range(0, 3) != 0);
                1: rsp.ready <= 1'b1;
                default: rsp.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    initial
    begin
        int burst;
        int k;
        int waited;
        bit hold_done;
        cmd.valid        <= 1'b0;
        cmd.req_type     <= REQ_WRITE;
        cmd.mem_address  <= '0;
        cmd.sample_byte  <= '0;
        cmd.rate_hz      <= '0;
        cmd.sample_total <= '0;
        cmd.voice_handle <= '0;
        cmd.gain         <= '0;
        cmd.pan          <= '0;
        long_hold = 1'b0;
        hold_done = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the sound region, extremes at its start, plus the last address
        for (k = 0; k < SOUND_BYTES; k++)
            send_req(REQ_WRITE, 15'(k), (k < 4) ? 8'(k * 255 / 3) : 8'($urandom),
                     '0, '0, '0, '0, '0);
        send_req(REQ_WRITE, 15'h7fff, 8'h00, '0, '0, '0, '0, '0);
        send_req(REQ_WRITE, 15'h7fff, 8'hff, '0, '0, '0, '0, '0);

        // directed: rejected starts, full range, pan clip, extremes, odd handles, unknown codes and ticks
        send_req(REQ_START, 15'd0, 8'd0, 16'd0, 16'd4, '0, 7'd127, 8'd0);
        send_req(REQ_START, 15'd0, 8'd0, 16'd11025, 16'd0, '0, 7'd127, 8'd0);
        send_req(REQ_START, 15'h7fff, 8'd0, 16'd11025, 16'd2, '0, 7'd127, 8'd0);
        send_req(REQ_START, 15'd0, 8'd0, 16'd11025, 16'd32768, '0, 7'd127, 8'd0);
        send_req(REQ_STOP, '0, '0, '0, '0, 4'd1, '0, '0);
        send_req(REQ_START, 15'h7fff, 8'd0, 16'd1, 16'd1, '0, 7'd127, 8'd255);
        send_req(REQ_START, 15'd0, 8'd0, 16'hffff, 16'd4, '0, 7'd127, 8'd0);
        for (k = 0; k < 7; k++)
            send_req(REQ_START, 15'd0, 8'd0, 16'd11025, 16'd4, 4'hf, 7'd127,
                     8'(k * 127 / 3));
        send_req(REQ_START, 15'd0, 8'd0, 16'd11025, 16'd4, '0, 7'd127, 8'd0);
        send_req(REQ_QUERY, '0, '0, '0, '0, 4'd0, '0, '0);
        send_req(REQ_QUERY, '0, '0, '0, '0, 4'd15, '0, '0);
        send_req(REQ_QUERY, '0, '0, '0, '0, 4'd8, '0, '0);
        send_req(REQ_SETP, '0, '0, '0, '0, 4'd9, 7'd0, 8'd255);
        send_req(3'd6, 15'h7fff, 8'hff, 16'hffff, 16'hffff, 4'hf, 7'h7f, 8'hff);
        send_req(3'd7, '0, '0, '0, '0, '0, '0, '0);
        for (k = 0; k < 6; k++)
            send_req(REQ_TICK, '0, '0, '0, '0, '0, '0, '0);
        drop_valid();

        // random bursts: mostly starts and ticks so voices play out
        k = 0;
        while (k < 700)
        begin
            burst = $urandom_range(1, 20);
            if (k >= 300 && !hold_done)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            repeat (burst)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    send_start($urandom_range(0, 1));
                    3:          send_req(REQ_STOP, '0, '0, '0, '0, 4'($urandom), '0, '0);
                    4:          send_req(REQ_SETP, '0, '0, '0, '0, 4'($urandom),
                                         7'($urandom), 8'($urandom));
                    5:          send_req(REQ_QUERY, '0, '0, '0, '0, 4'($urandom), '0, '0);
                    6:          send_req(REQ_WRITE, 15'($urandom_range(0, SOUND_BYTES - 1)),
                                         8'($urandom), '0, '0, '0, '0, '0);
                    7:          send_req(3'($urandom_range(6, 7)), 15'($urandom), 8'($urandom),
                                         16'($urandom), 16'($urandom), 4'($urandom),
                                         7'($urandom), 8'($urandom));
                    default:    send_req(REQ_TICK, 15'($urandom), 8'($urandom),
                                         16'($urandom), 16'($urandom), 4'($urandom),
                                         7'($urandom), 8'($urandom));
                endcase
                k++;
            end
            drop_valid();
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25)) @(posedge clk);
        end
        drop_valid();

        // drain, then let the back end settle
        waited = 0;
        while (pending_count != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/pcmx_pkg.sv
hdl/pcmx_ifs.sv
hdl/pcmx_ram.sv
hdl/pcmx_front.sv
hdl/pcmx_back.sv
hdl/pcm_channel_mixer.sv
hdl/pcmx_checker.sv
sim/pcm_channel_mixer_checker.sv
sim/pcm_channel_mixer_tb.sv
